// ----- design/sliding_window_min_max_top_macros.svh -----
// Assertion macros for the sliding window min/max block.
// Used by modules that assert; expects clk_i and rst_ni in scope.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SWMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/swmm_pkg.sv -----
// Shared constants and item types for the sliding window min/max block.
// No dependencies.
package swmm_pkg;

  localparam int MaxWindow = 64;
  localparam int SampleW   = 16;
  localparam int AddrW     = $clog2(MaxWindow);
  localparam int CntW      = $clog2(MaxWindow + 1);

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] window_min;
    logic signed [SampleW-1:0] window_max;
    logic                      last_res;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// ----- design/swmm_ram.sv -----
// Sample store: one write port, one read port, registered read data.
// Depends on swmm_pkg.
module swmm_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [swmm_pkg::AddrW-1:0]   waddr_i,
  input  logic [swmm_pkg::SampleW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [swmm_pkg::AddrW-1:0]   raddr_i,
  output logic [swmm_pkg::SampleW-1:0] rdata_o
);
  import swmm_pkg::*;

  logic [SampleW-1:0] mem [MaxWindow];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/swmm_ctrl.sv -----
// Window controller: writes samples to the store and rescans the window.
// Depends on swmm_pkg, swmm_ram and the assertion macro header.
`include "sliding_window_min_max_top_macros.svh"

module swmm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [swmm_pkg::CntW-1:0] win_size_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  swmm_pkg::in_t            in_data_i,
  output swmm_pkg::res_t           res_o,
  input  logic                     res_take_i
);
  import swmm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_e;

  state_e                    state_q;
  logic [AddrW-1:0]          wpos_q;
  logic [CntW-1:0]           fill_q;
  logic [AddrW-1:0]          rd_addr_q;
  logic [CntW-1:0]           left_q;
  logic                      rvalid_q;
  logic signed [SampleW-1:0] lo_q;
  logic signed [SampleW-1:0] hi_q;
  logic                      last_q;

  logic                      accept;
  logic [CntW-1:0]           fill_inc;
  logic                      re;
  logic [SampleW-1:0]        rdata;
  logic signed [SampleW-1:0] rd_s;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_inc   = (fill_q == CntW'(MaxWindow)) ? fill_q : fill_q + 1'b1;
  assign re         = (state_q == ST_SCAN) && (left_q != '0);
  assign rd_s       = $signed(rdata);

  assign res_o.valid           = (state_q == ST_DONE);
  assign res_o.data.window_min = lo_q;
  assign res_o.data.window_max = hi_q;
  assign res_o.data.last_res   = last_q;

  swmm_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wpos_q),
    .wdata_i (in_data_i.sample),
    .re_i    (re),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wpos_q    <= '0;
      fill_q    <= '0;
      rd_addr_q <= '0;
      left_q    <= '0;
      rvalid_q  <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      last_q    <= 1'b0;
    end else begin
      rvalid_q <= re;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            lo_q      <= in_data_i.sample;
            hi_q      <= in_data_i.sample;
            last_q    <= in_data_i.last;
            rd_addr_q <= wpos_q - 1'b1;
            left_q    <= win_size_i - 1'b1;
            wpos_q    <= in_data_i.last ? '0 : wpos_q + 1'b1;
            fill_q    <= in_data_i.last ? '0 : fill_inc;
            if (fill_inc >= win_size_i) begin
              state_q <= (win_size_i == CntW'(1)) ? ST_DONE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (re) begin
            rd_addr_q <= rd_addr_q - 1'b1;
            left_q    <= left_q - 1'b1;
          end
          if (rvalid_q) begin
            if (rd_s < lo_q) lo_q <= rd_s;
            if (rd_s > hi_q) hi_q <= rd_s;
            if (left_q == '0) state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take_i) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SWMM_ASSERT(a_min_le_max, res_o.valid |-> (lo_q <= hi_q), "window min above max")
  `SWMM_ASSERT(a_fill_range, fill_q <= CntW'(MaxWindow), "fill count beyond store depth")
  `SWMM_ASSERT(a_rd_in_scan, rvalid_q |-> (state_q == ST_SCAN), "read data outside scan")
  `SWMM_ASSERT_NEXT(a_last_clears, accept && in_data_i.last, (fill_q == '0) && (wpos_q == '0), "sequence end did not clear window")

endmodule

// ----- design/sliding_window_min_max_top.sv -----
// Sliding window min/max, top level: window size register, controller, output register.
// An item that completes a window is rescanned through the single store read port (skipped for a
// size of one); its result then waits in the controller until the output register takes it,
// and input stalls from its accept until then. An item short of a full window does not stall.
// An item is taken while the previous result still waits in the output register.
// Reset: window size 1, empty window, no result pending; the store needs no clearing.
module sliding_window_min_max_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swmm_pkg::CntW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  swmm_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output swmm_pkg::out_t            out_data_o
);
  import swmm_pkg::*;

  logic [CntW-1:0] size_q;
  logic [CntW-1:0] size_eff;
  res_t            res;
  logic            res_take;
  logic            out_valid_q;
  out_t            out_q;

  always_comb begin
    if (size_q == '0) begin
      size_eff = CntW'(1);
    end else if (size_q > CntW'(MaxWindow)) begin
      size_eff = CntW'(MaxWindow);
    end else begin
      size_eff = size_q;
    end
  end

  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  swmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_size_i (size_eff),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_o      (res),
    .res_take_i (res_take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= CntW'(1);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (res_take) begin
        out_valid_q <= 1'b1;
        out_q       <= res.data;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_min_max_top: streams sample sequences under
// a range of window sizes and idling patterns, checks each min/max result against a predictor.
// Depends on swmm_pkg and the sliding_window_min_max_top RTL.
module testbench;
  import swmm_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 80;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;

  in_t  pending_samples[$];
  out_t expected_minmax[$];
  out_t want;

  logic signed [SampleW-1:0] window_hist [MaxWindow];
  logic [AddrW-1:0]          wr_pos   = '0;
  int unsigned               fill     = 0;
  logic [CntW-1:0]           win_size = 1;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors    = 0;
  int unsigned n_items   = 0;
  int unsigned n_results = 0;
  int unsigned cycle     = 0;

  sliding_window_min_max_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_span(logic [CntW-1:0] s);
    if (s == 0) return 1;
    if (s > MaxWindow) return MaxWindow;
    return s;
  endfunction

  function automatic void predict_min_max(in_t item);
    int unsigned               span;
    logic signed [SampleW-1:0] lo, hi, v;
    out_t                      res;
    span = eff_span(win_size);
    window_hist[wr_pos] = item.sample;
    wr_pos = wr_pos + 1'b1;  // wraps at MaxWindow
    if (fill < MaxWindow) fill++;
    if (fill >= span) begin
      lo = window_hist[AddrW'(wr_pos - 1)];
      hi = lo;
      for (int i = 1; i < span; i++) begin
        v = window_hist[AddrW'(wr_pos - 1 - i)];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      res.window_min = lo;
      res.window_max = hi;
      res.last_res   = item.last;
      expected_minmax.push_back(res);
    end
    if (item.last) begin
      fill   = 0;
      wr_pos = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic push_item(input logic signed [SampleW-1:0] s, input logic l);
    in_t it;
    it.sample = s;
    it.last   = l;
    pending_samples.push_back(it);
  endtask

  task automatic wait_results();
    while (pending_samples.size() != 0 || in_valid_i || expected_minmax.size() != 0)
      @(negedge clk_i);
  endtask

  // waits until no results are expected, then lets the block settle
  task automatic drain_all();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CntW-1:0] value);
    drain_all();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    win_size = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic gen_items(input int unsigned budget);
    int unsigned               span, len, kind;
    logic signed [SampleW-1:0] s;
    span = eff_span(win_size);
    while (budget > 0) begin
      kind = $urandom_range(9);
      if (kind < 6) len = $urandom_range(span + 12, span);
      else if (kind == 6) len = (span > 1) ? $urandom_range(span - 1, 1) : 1;
      else if (kind == 7) len = $urandom_range(100, 60);
      else len = $urandom_range(20, 1);
      for (int k = 0; k < len && budget > 0; k++) begin
        case ($urandom_range(7))
          0:       s = {1'b1, {(SampleW-1){1'b0}}};
          1:       s = {1'b0, {(SampleW-1){1'b1}}};
          2:       s = SampleW'($urandom_range(8) - 4);
          default: s = SampleW'($urandom);
        endcase
        push_item(s, k == len - 1);
        budget--;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_min_max(in_data_i);
        n_items++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_minmax.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_minmax.pop_front();
          if (out_data_o.window_min !== want.window_min)
            report_mismatch($sformatf("window_min got %0d want %0d",
                                      out_data_o.window_min, want.window_min));
          if (out_data_o.window_max !== want.window_max)
            report_mismatch($sformatf("window_max got %0d want %0d",
                                      out_data_o.window_max, want.window_max));
          if (out_data_o.last_res !== want.last_res)
            report_mismatch($sformatf("last_res got %b want %b",
                                      out_data_o.last_res, want.last_res));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle++;
    if (cycle == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle, expected_minmax.size());
      $display("** sliding_window_min_max_top: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [CntW-1:0] sz;
    send_idle_pct  = 21;
    recv_stall_pct = 59;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset size of one: every item gives a result
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh0000, 1'b1);
    // zero acts as one
    write_window(0);
    push_item(-1, 1'b1);
    // full sequence, then a short one that gives nothing
    write_window(3);
    push_item(5, 1'b0);
    push_item(-5, 1'b0);
    push_item(2, 1'b0);
    push_item(9, 1'b1);
    push_item(1, 1'b0);
    push_item(2, 1'b1);
    // oversize register value clamps to the store depth
    write_window(127);
    push_item(7, 1'b0);
    push_item(-7, 1'b1);
    // size raised while a sequence is open
    write_window(2);
    push_item(100, 1'b0);
    push_item(-200, 1'b0);
    push_item(300, 1'b0);
    write_window(4);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7fff, 1'b1);
    write_window(64);
    push_item(3, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        3:       sz = 64;
        7:       sz = 127;
        10:      sz = 0;
        default: sz = ($urandom_range(4) == 0) ? CntW'($urandom_range(127))
                                               : CntW'($urandom_range(8, 1));
      endcase
      write_window(sz);
      case (ph / 4)
        0: begin
          send_idle_pct  = 21;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph == 9) begin
        gen_items(40);
        wait_results();
        gen_items(40);
      end else begin
        gen_items(80);
      end
    end
    drain_all();

    $display("Ran %0d items and checked %0d min/max results in %0d cycles,", n_items,
             n_results, cycle);
    $display("window sizes 0 to 127 incl. mid-sequence changes, under three idling patterns.");
    if (errors == 0) begin
      $display("** sliding_window_min_max_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** sliding_window_min_max_top: FAILED **");
    end
    $finish;
  end

endmodule
